>>> rtl/core/hfcm_pkg.sv
// Shared types, constants and helpers for the HTTP field content matcher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hfcm_pkg;

  localparam int PATTERN_MAX_DEF   = 32;
  localparam int HISTORY_DEPTH_DEF = 40;

  // Pattern storage is fixed at four 64-bit words.
  localparam int PAT_WORDS  = 4;
  localparam int PAT_BYTES  = 8 * PAT_WORDS;
  localparam int PAT_IDX_W  = 5;

  // Longest close marker and longest open marker, in bytes.
  localparam int CLOSE_MAX  = 5;
  localparam int MK_SPAN    = 12;

  localparam logic [5:0] LEN_SAT = 6'd63;

  localparam logic [1:0] PH_SEEK   = 2'd0;
  localparam logic [1:0] PH_INSIDE = 2'd1;
  localparam logic [1:0] PH_CLOSED = 2'd2;
  localparam logic [1:0] PH_EMPTY  = 2'd3;

  localparam logic [2:0] MODE_WHOLE  = 3'd0;
  localparam logic [2:0] MODE_URI    = 3'd1;
  localparam logic [2:0] MODE_HOST   = 3'd2;
  localparam logic [2:0] MODE_AGENT  = 3'd3;
  localparam logic [2:0] MODE_COOKIE = 3'd4;

  localparam logic [2:0] REG_FIELD_MODE     = 3'd0;
  localparam logic [2:0] REG_FOLD_CASE      = 3'd1;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [2:0] REG_PATTERN_WORD_0 = 3'd3;
  localparam logic [2:0] REG_PATTERN_WORD_1 = 3'd4;
  localparam logic [2:0] REG_PATTERN_WORD_2 = 3'd5;
  localparam logic [2:0] REG_PATTERN_WORD_3 = 3'd6;

  // Markers, newest byte in the lowest bits.
  localparam logic [15:0] MK_URI_OPEN  = " /";
  localparam logic [39:0] MK_URI_CLOSE = " HTTP";
  localparam logic [47:0] MK_HOST      = "Host: ";
  localparam logic [95:0] MK_AGENT     = "User-Agent: ";
  localparam logic [63:0] MK_COOKIE    = "Cookie: ";
  localparam logic [15:0] MK_CRLF      = "\r\n";

  localparam logic [2:0] CLOSE_N_URI  = 3'd5;
  localparam logic [2:0] CLOSE_N_CRLF = 3'd2;
  localparam logic [2:0] CLOSE_N_NONE = 3'd0;

  typedef struct packed {
    logic [2:0]             field_mode;
    logic                   fold_case;
    logic [5:0]             pattern_length;
    logic [8*PAT_BYTES-1:0] pattern_words;
  } cfg_t;

  typedef struct packed {
    logic content_match;
    logic region_found;
  } res_t;

  function automatic logic [7:0] fold_byte(input logic en, input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hfcm_cfg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on hfcm_pkg for register indexes and the configuration struct.
`default_nettype none

module hfcm_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output hfcm_pkg::cfg_t     cfg
);
  import hfcm_pkg::*;

  logic [2:0]  field_mode_r;
  logic        fold_case_r;
  logic [5:0]  pattern_length_r;
  logic [63:0] pattern_word_r [PAT_WORDS];
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_mode_r     <= MODE_WHOLE;
      fold_case_r      <= 1'b0;
      pattern_length_r <= 6'd0;
      for (int w = 0; w < PAT_WORDS; w++) begin
        pattern_word_r[w] <= 64'd0;
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FIELD_MODE:     field_mode_r      <= pwdata[2:0];
        REG_FOLD_CASE:      fold_case_r       <= pwdata[0];
        REG_PATTERN_LENGTH: pattern_length_r  <= pwdata[5:0];
        REG_PATTERN_WORD_0: pattern_word_r[0] <= pwdata;
        REG_PATTERN_WORD_1: pattern_word_r[1] <= pwdata;
        REG_PATTERN_WORD_2: pattern_word_r[2] <= pwdata;
        REG_PATTERN_WORD_3: pattern_word_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FIELD_MODE:     prdata = {61'd0, field_mode_r};
      REG_FOLD_CASE:      prdata = {63'd0, fold_case_r};
      REG_PATTERN_LENGTH: prdata = {58'd0, pattern_length_r};
      REG_PATTERN_WORD_0: prdata = pattern_word_r[0];
      REG_PATTERN_WORD_1: prdata = pattern_word_r[1];
      REG_PATTERN_WORD_2: prdata = pattern_word_r[2];
      REG_PATTERN_WORD_3: prdata = pattern_word_r[3];
      default:            prdata = 64'd0;
    endcase
  end

  assign cfg.field_mode     = field_mode_r;
  assign cfg.fold_case      = fold_case_r;
  assign cfg.pattern_length = pattern_length_r;
  assign cfg.pattern_words  = {pattern_word_r[3], pattern_word_r[2],
                               pattern_word_r[1], pattern_word_r[0]};

endmodule

`default_nettype wire

>>> rtl/core/hfcm_pat_cmp.sv
// Parallel compare of the configured pattern against a window of payload bytes.
// Depends on hfcm_pkg for the case-fold helper and pattern storage sizes.
`default_nettype none

module hfcm_pat_cmp #(
  parameter int PATTERN_MAX = hfcm_pkg::PATTERN_MAX_DEF
) (
  input  logic [7:0]                        seg [PATTERN_MAX],
  input  logic                              fold_case,
  input  logic [5:0]                        pattern_length,
  input  logic [8*hfcm_pkg::PAT_BYTES-1:0]  pattern_words,
  output logic                              hit
);
  import hfcm_pkg::*;

  logic [5:0]           diff;
  logic [PAT_IDX_W-1:0] idx;
  logic [7:0]           pat_b;

  // Window byte k lines up with pattern byte (length - 1 - k).
  always_comb begin
    diff  = 6'd0;
    idx   = '0;
    pat_b = 8'd0;
    hit   = (pattern_length != 6'd0) && (pattern_length <= 6'(PATTERN_MAX));
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (6'(k) < pattern_length) begin
        diff  = pattern_length - 6'(k) - 6'd1;
        idx   = diff[PAT_IDX_W-1:0];
        pat_b = pattern_words[{idx, 3'b000} +: 8];
        if (fold_byte(fold_case, seg[k]) != fold_byte(fold_case, pat_b)) begin
          hit = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hfcm_scan.sv
// Per-packet scanner: byte history, region tracking and the packet result.
// Depends on hfcm_pkg and instantiates hfcm_pat_cmp.
`default_nettype none

module hfcm_scan #(
  parameter int PATTERN_MAX   = hfcm_pkg::PATTERN_MAX_DEF,
  parameter int HISTORY_DEPTH = hfcm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hfcm_pkg::cfg_t  cfg,
  input  logic            step,
  input  logic [7:0]      payload_byte,
  input  logic            last_byte,
  input  logic            is_http,
  input  logic            no_payload,
  output logic            ends,
  output hfcm_pkg::res_t  res
);
  import hfcm_pkg::*;

  localparam int WIN_LEN = PATTERN_MAX + CLOSE_MAX;

  logic [7:0]  hist_r   [HISTORY_DEPTH];
  logic [7:0]  hist_sh  [HISTORY_DEPTH];
  logic [7:0]  win      [WIN_LEN];
  logic [7:0]  seg      [PATTERN_MAX];
  logic [8*MK_SPAN-1:0] recent;

  logic [1:0]  phase_r, phase_nxt, phase_a, phase_f;
  logic [5:0]  len_r, len_nxt, len_a, len_b;
  logic        hit_r, hit_nxt, hit_a;
  logic        first_r, first_nxt;
  logic        http_r, http_nxt, http_cur;

  logic        take, whole, is_uri, proc;
  logic        open_hit, close_hit, pat_hit, found;
  logic [2:0]  close_n;

  assign hist_sh[0] = payload_byte;
  for (genvar i = 1; i < HISTORY_DEPTH; i++) begin : g_shift
    assign hist_sh[i] = hist_r[i-1];
  end

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_win
    if (i < HISTORY_DEPTH) begin : g_in
      assign win[i] = hist_sh[i];
    end else begin : g_out
      assign win[i] = 8'h00;
    end
  end

  for (genvar i = 0; i < MK_SPAN; i++) begin : g_recent
    assign recent[8*i +: 8] = hist_sh[i];
  end

  assign whole  = !((cfg.field_mode >= MODE_URI) && (cfg.field_mode <= MODE_COOKIE));
  assign is_uri = (cfg.field_mode == MODE_URI);

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_seg
    assign seg[k] = whole ? win[k] : (is_uri ? win[k + 5] : win[k + 2]);
  end

  hfcm_pat_cmp #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_pat_cmp (
    .seg            (seg),
    .fold_case      (cfg.fold_case),
    .pattern_length (cfg.pattern_length),
    .pattern_words  (cfg.pattern_words),
    .hit            (pat_hit)
  );

  always_comb begin
    case (cfg.field_mode)
      MODE_URI: begin
        open_hit  = (recent[15:0] == MK_URI_OPEN);
        close_hit = (recent[39:0] == MK_URI_CLOSE);
        close_n   = CLOSE_N_URI;
      end
      MODE_HOST: begin
        open_hit  = (recent[47:0] == MK_HOST);
        close_hit = (recent[15:0] == MK_CRLF);
        close_n   = CLOSE_N_CRLF;
      end
      MODE_AGENT: begin
        open_hit  = (recent[95:0] == MK_AGENT);
        close_hit = (recent[15:0] == MK_CRLF);
        close_n   = CLOSE_N_CRLF;
      end
      MODE_COOKIE: begin
        open_hit  = (recent[63:0] == MK_COOKIE);
        close_hit = (recent[15:0] == MK_CRLF);
        close_n   = CLOSE_N_CRLF;
      end
      default: begin
        open_hit  = 1'b0;
        close_hit = 1'b0;
        close_n   = CLOSE_N_NONE;
      end
    endcase
  end

  always_comb begin
    take     = !no_payload;
    ends     = last_byte || no_payload;
    http_cur = first_r ? is_http : http_r;
    phase_a  = phase_r;
    len_a    = len_r;
    len_b    = len_r;
    hit_a    = hit_r;
    proc     = 1'b0;

    if (take) begin
      if (phase_r == PH_SEEK) begin
        if (whole) begin
          phase_a = PH_INSIDE;
          len_a   = 6'd0;
          proc    = 1'b1;
        end else if (open_hit) begin
          phase_a = PH_INSIDE;
          len_a   = is_uri ? 6'd1 : 6'd0;
        end
      end else if (phase_r == PH_INSIDE) begin
        proc = 1'b1;
      end

      if (proc) begin
        len_b = (len_a == LEN_SAT) ? len_a : len_a + 6'd1;
        len_a = len_b;
        if (({1'b0, len_b} >= ({4'd0, close_n} + {1'b0, cfg.pattern_length})) && pat_hit) begin
          hit_a = 1'b1;
        end
        if (!whole && (len_b >= {3'd0, close_n}) && close_hit) begin
          phase_a = (len_b > {3'd0, close_n}) ? PH_CLOSED : PH_EMPTY;
        end
      end
    end

    phase_f = phase_a;
    if ((phase_a == PH_INSIDE) && whole) begin
      phase_f = (len_a != 6'd0) ? PH_CLOSED : PH_EMPTY;
    end
    found             = (phase_f == PH_CLOSED);
    res.region_found  = found;
    res.content_match = !http_cur || (found && hit_a);

    phase_nxt = ends ? PH_SEEK : phase_a;
    len_nxt   = ends ? 6'd0    : len_a;
    hit_nxt   = ends ? 1'b0    : hit_a;
    first_nxt = ends;
    http_nxt  = ends ? 1'b0    : http_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      len_r   <= 6'd0;
      hit_r   <= 1'b0;
      first_r <= 1'b1;
      http_r  <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= 8'h00;
      end
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      hit_r   <= hit_nxt;
      first_r <= first_nxt;
      http_r  <= http_nxt;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        if (ends) begin
          hist_r[i] <= 8'h00;
        end else if (take) begin
          hist_r[i] <= hist_sh[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/http_field_content_matcher.sv
// Top level of the HTTP field content matcher: input stage, scanner, result stage.
// Depends on hfcm_pkg, hfcm_cfg_regs, hfcm_scan and hfcm_pat_cmp.
`default_nettype none

// The block takes one payload byte per clock cycle when its input is not stalled
// and gives one result transfer per packet, on the item that ends it. An accepted
// byte is held in the input register while the scanner updates its history and
// region state; the result enters the output register, which drives out_valid, as
// the ending byte leaves the input register. The input and output registers are
// separate, so bytes keep flowing while a result waits; only a packet-ending byte
// waits behind an untaken result. The rate is set by the single pass of marker and
// pattern compares over the byte history. Configuration registers sit at byte
// address 8 times their index and take an ordinary setup and access write; the
// user must write them only while no packet is in flight; the block does not check.
module http_field_content_matcher #(
  parameter int PATTERN_MAX   = hfcm_pkg::PATTERN_MAX_DEF,
  parameter int HISTORY_DEPTH = hfcm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_last_byte,
  input  logic        in_is_http,
  input  logic        in_no_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_content_match,
  output logic        out_region_found,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import hfcm_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_http_r;
  logic       s1_none_r;
  logic       s1_ends;
  logic       advance;
  logic       out_v_r;
  res_t       out_r;

  hfcm_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hfcm_scan #(
    .PATTERN_MAX   (PATTERN_MAX),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step         (advance),
    .payload_byte (s1_byte_r),
    .last_byte    (s1_last_r),
    .is_http      (s1_http_r),
    .no_payload   (s1_none_r),
    .ends         (s1_ends),
    .res          (res)
  );

  assign advance  = s1_v_r && (!s1_ends || !out_v_r || out_ready);
  assign in_ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_payload_byte;
      s1_last_r <= in_last_byte;
      s1_http_r <= in_is_http;
      s1_none_r <= in_no_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && s1_ends) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_ends) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_content_match = out_r.content_match;
  assign out_region_found  = out_r.region_found;

  // A packet-ending byte never overwrites a result that has not been taken.
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_ends && out_v_r && !out_ready) |-> !advance)
    else $error("packet end advanced over a pending result");

  // A finished packet always raises out_valid in the next cycle.
  a_result_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_ends) |=> out_v_r)
    else $error("packet end gave no result");

  // The input side only stalls behind a held packet-ending byte while a result is pending.
  a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && s1_ends && out_v_r))
    else $error("input stalled without a waiting packet end");

endmodule

`default_nettype wire

>>> tb/hfcm_checker.sv
// Checker for the HTTP field content matcher: watches the byte, result and register ports,
// predicts the result of every packet and compares it with what the block returns.
// Depends on hfcm_pkg for register indexes, field modes, search phases and the result type.
module hfcm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_last_byte,
  input  logic        in_is_http,
  input  logic        in_no_payload,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_content_match,
  input  logic        out_region_found,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import hfcm_pkg::*;

  localparam int HIST_LEN    = HISTORY_DEPTH_DEF;
  localparam int MAX_PAT     = PATTERN_MAX_DEF;
  localparam int MAX_REPORTS = 10;
  localparam logic [5:0] RLEN_MAX = 6'd63;
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;

  localparam logic [95:0] OPEN_URI_MK  = " /";
  localparam logic [95:0] CLOSE_URI_MK = " HTTP";
  localparam logic [95:0] HOST_MK      = "Host: ";
  localparam logic [95:0] AGENT_MK     = "User-Agent: ";
  localparam logic [95:0] COOKIE_MK    = "Cookie: ";
  localparam logic [95:0] CRLF_MK      = "\r\n";

  logic [2:0]   mode_q;
  logic         fold_q;
  logic [5:0]   plen_q;
  logic [255:0] pat_q;

  logic [7:0]   hist_q [HIST_LEN];
  logic [1:0]   phase_q;
  logic [5:0]   rlen_q;
  logic         hit_q;
  logic         first_q;
  logic         http_q;

  res_t         packet_verdicts [$];

  function automatic logic [7:0] past_byte(input int lag);
    if (lag < HIST_LEN) begin
      return hist_q[lag];
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] lower_if(input logic [7:0] b);
    if (fold_q && b >= UPPER_A && b <= UPPER_Z) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  function automatic bit tail_is(input logic [95:0] mk, input int n);
    for (int k = 0; k < n; k++) begin
      if (past_byte(k) != mk[8*k +: 8]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit pattern_ends_at(input int lag);
    int p;
    p = plen_q;
    if (p == 0 || p > MAX_PAT) begin
      return 1'b0;
    end
    for (int k = 0; k < p; k++) begin
      if (lower_if(past_byte(lag + k)) != lower_if(pat_q[8*(p-1-k) +: 8])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_packet();
    for (int i = 0; i < HIST_LEN; i++) begin
      hist_q[i] = 8'h00;
    end
    phase_q = PH_SEEK;
    rlen_q  = '0;
    hit_q   = 1'b0;
    first_q = 1'b1;
    http_q  = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    logic [95:0] open_mk;
    logic [95:0] close_mk;
    int          open_n;
    int          close_n;
    int          open_len;
    open_mk  = '0;
    close_mk = CRLF_MK;
    open_n   = 0;
    close_n  = 2;
    open_len = 0;
    case (mode_q)
      MODE_URI: begin
        open_mk  = OPEN_URI_MK;
        open_n   = 2;
        open_len = 1;
        close_mk = CLOSE_URI_MK;
        close_n  = 5;
      end
      MODE_HOST: begin
        open_mk = HOST_MK;
        open_n  = 6;
      end
      MODE_AGENT: begin
        open_mk = AGENT_MK;
        open_n  = 12;
      end
      MODE_COOKIE: begin
        open_mk = COOKIE_MK;
        open_n  = 8;
      end
      default: begin
        close_n = 0;
      end
    endcase

    for (int i = HIST_LEN - 1; i > 0; i--) begin
      hist_q[i] = hist_q[i-1];
    end
    hist_q[0] = b;

    if (phase_q == PH_SEEK) begin
      if (open_n == 0) begin
        phase_q = PH_INSIDE;
        rlen_q  = '0;
      end else begin
        if (tail_is(open_mk, open_n)) begin
          phase_q = PH_INSIDE;
          rlen_q  = 6'(open_len);
        end
        return;
      end
    end
    if (phase_q != PH_INSIDE) begin
      return;
    end

    if (rlen_q != RLEN_MAX) begin
      rlen_q = rlen_q + 6'd1;
    end
    if (int'(rlen_q) >= close_n + int'(plen_q) && pattern_ends_at(close_n)) begin
      hit_q = 1'b1;
    end
    if (close_n != 0 && int'(rlen_q) >= close_n && tail_is(close_mk, close_n)) begin
      phase_q = (int'(rlen_q) > close_n) ? PH_CLOSED : PH_EMPTY;
    end
  endtask

  task automatic advance_matcher();
    logic ends;
    res_t verdict;
    ends = in_last_byte;
    if (first_q) begin
      http_q  = in_is_http;
      first_q = 1'b0;
    end
    if (in_no_payload) begin
      ends = 1'b1;
    end else begin
      scan_byte(in_payload_byte);
    end
    if (!ends) begin
      return;
    end
    if (phase_q == PH_INSIDE && (mode_q == MODE_WHOLE || mode_q > MODE_COOKIE)) begin
      phase_q = (rlen_q != 0) ? PH_CLOSED : PH_EMPTY;
    end
    verdict.region_found  = (phase_q == PH_CLOSED);
    verdict.content_match = !http_q || (verdict.region_found && hit_q);
    packet_verdicts.push_back(verdict);
    clear_packet();
  endtask

  task automatic compare_result();
    res_t want;
    if (packet_verdicts.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: result transfer with no packet outstanding: content_match %0b region_found %0b",
                 $time, out_content_match, out_region_found);
      end
      return;
    end
    want = packet_verdicts.pop_front();
    results_seen++;
    if (want.content_match !== out_content_match || want.region_found !== out_region_found) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: packet %0d: content_match expected %0b got %0b, region_found expected %0b got %0b",
                 $time, results_seen, want.content_match, out_content_match,
                 want.region_found, out_region_found);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q       = MODE_WHOLE;
      fold_q       = 1'b0;
      plen_q       = '0;
      pat_q        = '0;
      fail_count   = 0;
      results_seen = 0;
      packet_verdicts.delete();
      clear_packet();
    end else begin
      if (out_valid && out_ready) begin
        compare_result();
      end
      if (in_valid && in_ready) begin
        advance_matcher();
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_FIELD_MODE:     mode_q = pwdata[2:0];
          REG_FOLD_CASE:      fold_q = pwdata[0];
          REG_PATTERN_LENGTH: plen_q = pwdata[5:0];
          REG_PATTERN_WORD_0: pat_q[63:0]    = pwdata;
          REG_PATTERN_WORD_1: pat_q[127:64]  = pwdata;
          REG_PATTERN_WORD_2: pat_q[191:128] = pwdata;
          REG_PATTERN_WORD_3: pat_q[255:192] = pwdata;
          default: ;
        endcase
      end
    end
    pending = packet_verdicts.size();
  end

endmodule

>>> tb/tb_http_field_content_matcher.sv
// Top of the testbench for the HTTP field content matcher: clock, reset, register setup,
// packet stimulus with random pacing on both channels, and the final verdict.
// Depends on hfcm_pkg, the block http_field_content_matcher and the checker hfcm_checker.
module tb_http_field_content_matcher;
  import hfcm_pkg::*;

  localparam int RANDOM_ITEMS  = 850;
  localparam int QUIET_ITEMS   = 80;
  localparam int MIN_RESULTS   = 40;
  localparam int PHASE_ITEMS   = 70;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  in_payload_byte = 8'h00;
  logic        in_last_byte    = 1'b0;
  logic        in_is_http      = 1'b0;
  logic        in_no_payload   = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic        out_content_match;
  logic        out_region_found;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [5:0]  paddr           = '0;
  logic [63:0] pwdata          = '0;
  logic [63:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int results_seen;

  bit         quiet         = 1'b0;
  bit         hold_req      = 1'b0;
  int         gap_pct       = 0;
  int         stall_pct     = 0;
  int         items_sent    = 0;
  int         settings_used = 0;
  int         cycle_count   = 0;
  int         plen_cur      = 0;
  logic       fold_cur      = 1'b0;
  logic [7:0] pat_bytes [PAT_BYTES];
  logic [7:0] pkt_bytes [$];
  string      text_chars    = "AaZzMmHTP@[{09 -/:\r\n";

  http_field_content_matcher u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload_byte   (in_payload_byte),
    .in_last_byte      (in_last_byte),
    .in_is_http        (in_is_http),
    .in_no_payload     (in_no_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_content_match (out_content_match),
    .out_region_found  (out_region_found),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  hfcm_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload_byte   (in_payload_byte),
    .in_last_byte      (in_last_byte),
    .in_is_http        (in_is_http),
    .in_no_payload     (in_no_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_content_match (out_content_match),
    .out_region_found  (out_region_found),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_seen      (results_seen)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The result side stalls in random bursts, and once holds off for a long stretch so that
  // the block fills up and pushes back on the byte side.
  initial begin : rx_pacing
    int idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) begin
          idle_left = $urandom_range(1, 19);
        end
      end
    end
  end

  function automatic logic [7:0] text_byte();
    return text_chars[$urandom_range(0, text_chars.len() - 1)];
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pkt_bytes.push_back(s[i]);
    end
  endtask

  task automatic add_field_value();
    int         pre;
    int         post;
    int         n;
    logic [7:0] b;
    pre  = $urandom_range(0, 4);
    post = $urandom_range(0, 3);
    if ($urandom_range(0, 19) == 0) begin
      pre = $urandom_range(10, 36);
    end
    repeat (pre) pkt_bytes.push_back(text_byte());
    if ($urandom_range(0, 9) < 4) begin
      n = (plen_cur > PAT_BYTES) ? PAT_BYTES : plen_cur;
      for (int j = 0; j < n; j++) begin
        b = pat_bytes[j];
        if (fold_cur && $urandom_range(0, 1) == 1 &&
            ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))) begin
          b = b ^ 8'h20;
        end
        pkt_bytes.push_back(b);
      end
    end
    repeat (post) pkt_bytes.push_back(text_byte());
  endtask

  task automatic build_noise(input int max_len);
    pkt_bytes.delete();
    repeat ($urandom_range(1, max_len)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_item(input logic [7:0] b, input logic last, input logic http,
                           input logic nop);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_last_byte    <= last;
    in_is_http      <= http;
    in_no_payload   <= nop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_packet(input logic http, input bit allow_stray);
    logic first;
    first = 1'b1;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      if (allow_stray && $urandom_range(0, 49) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  first ? http : 1'($urandom_range(0, 1)), 1'b1);
        first = 1'b1;
      end
      send_item(pkt_bytes[i], i == pkt_bytes.size() - 1,
                first ? http : 1'($urandom_range(0, 1)), 1'b0);
      first = 1'b0;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [2:0] mode, input logic fold,
                                input logic [5:0] plen);
    logic [63:0] word;
    fold_cur = fold;
    plen_cur = plen;
    reg_write(REG_FIELD_MODE, 64'(mode));
    reg_write(REG_FOLD_CASE, 64'(fold));
    reg_write(REG_PATTERN_LENGTH, 64'(plen));
    for (int w = 0; w < PAT_WORDS; w++) begin
      for (int i = 0; i < 8; i++) begin
        word[8*i +: 8] = pat_bytes[8*w + i];
      end
      reg_write(REG_PATTERN_WORD_0 + 3'(w), word);
    end
    settings_used++;
  endtask

  initial begin : stimulus
    int         phase_idx;
    int         phase_start;
    int         random_start;
    int         kind;
    logic [2:0] mode;
    logic [5:0] plen;
    logic       fold;
    bit         hold_phase;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: whole payload, empty pattern.
    send_item(8'h00, 1'b1, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b1, 1'b0);

    wait_idle();
    for (int j = 0; j < PAT_BYTES; j++) begin
      pat_bytes[j] = 8'($urandom_range(0, 255));
    end
    pat_bytes[0] = "a";
    pat_bytes[1] = "B";
    apply_settings(MODE_URI, 1'b1, 6'd2);
    pkt_bytes.delete();
    add_text(" /Ab HTTP");
    send_packet(1'b1, 1'b0);

    wait_idle();
    apply_settings(MODE_HOST, 1'b0, 6'd1);
    pkt_bytes.delete();
    add_text("Host: \r\n");
    send_packet(1'b1, 1'b0);

    random_start = items_sent;
    phase_idx    = 0;
    while (items_sent - random_start < RANDOM_ITEMS || results_seen < MIN_RESULTS) begin
      wait_idle();
      case (phase_idx)
        0: mode = MODE_WHOLE;
        1: mode = MODE_URI;
        2: mode = MODE_HOST;
        3: mode = MODE_AGENT;
        4: mode = MODE_COOKIE;
        5: mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
          end else begin
            mode = 3'($urandom_range(MODE_WHOLE, MODE_COOKIE));
          end
        end
      endcase
      case (phase_idx)
        0: plen = 6'd0;
        1: plen = 6'd32;
        2: plen = 6'd1;
        3: plen = 6'd2;
        6: plen = 6'd63;
        7: plen = 6'd33;
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            plen = 6'($urandom_range(9, 32));
          end else begin
            plen = 6'($urandom_range(1, 8));
          end
        end
      endcase
      fold = (phase_idx < 2) ? 1'(phase_idx) : 1'($urandom_range(0, 1));
      for (int j = 0; j < PAT_BYTES; j++) begin
        if (j >= plen || phase_idx % 5 == 4) begin
          pat_bytes[j] = 8'($urandom_range(0, 255));
        end else begin
          pat_bytes[j] = text_byte();
        end
      end
      apply_settings(mode, fold, plen);

      gap_pct    = (phase_idx % 3 == 2) ? 0 : $urandom_range(5, 40);
      stall_pct  = (phase_idx % 4 == 1) ? 0 : $urandom_range(5, 40);
      hold_phase = (phase_idx == 3);
      if (hold_phase) begin
        hold_req = 1'b1;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (items_sent - random_start >= RANDOM_ITEMS - QUIET_ITEMS) begin
          quiet = 1'b1;
        end
        kind = $urandom_range(0, 9);
        if (hold_phase || kind == 7 || kind == 8) begin
          build_noise(hold_phase ? 3 : 12);
          send_packet(1'($urandom_range(0, 1)), 1'b1);
        end else if (kind == 9) begin
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b1);
        end else begin
          pkt_bytes.delete();
          if ($urandom_range(0, 2) == 0) begin
            add_text("GET");
          end
          if ($urandom_range(0, 19) != 0) begin
            add_text(" /");
          end else begin
            add_text("/");
          end
          add_field_value();
          case ($urandom_range(0, 9))
            0: add_text(" HTT");
            1: ;
            2, 3: add_text(" HTTP/1.1");
            default: add_text(" HTTP");
          endcase
          add_text("\r\n");
          repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 4))
              0: add_text("Host: ");
              1: add_text("User-Agent: ");
              2: add_text("Cookie: ");
              3: add_text("Accept: ");
              default: add_text("cookie: ");
            endcase
            add_field_value();
            if ($urandom_range(0, 9) != 0) begin
              add_text("\r\n");
            end
          end
          send_packet(kind != 0, 1'b1);
        end
      end
      phase_idx++;
    end

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers and %0d packet results under %0d register settings.",
             items_sent, results_seen, settings_used);
    $display("Settings spanned the five defined field modes, unused mode codes, pattern lengths");
    $display("from 0 to 63 and both case modes.");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
